// ===== rtl/cartesian_to_polar_unwrap_defines.svh =====
// assertion helpers used by cartesian_to_polar_unwrap
`ifndef CARTESIAN_TO_POLAR_UNWRAP_DEFINES_SVH
`define CARTESIAN_TO_POLAR_UNWRAP_DEFINES_SVH

// same-cycle implication
`define C2P_ASSERT_SAME(lbl, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define C2P_ASSERT_NEXT(lbl, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/c2p_pkg.sv =====
package c2p_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned CW         = 63;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned ANG_W      = 36;
  localparam int unsigned DB_W       = 16;

  localparam logic [DB_W-1:0] DEADBAND_RESET = 16'd268;

  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

  typedef struct packed {
    logic                    valid;
    logic                    origin;
    logic signed [WORD_W-1:0] cur;
    logic signed [WORD_W-1:0] folded;
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [CW-1:0]    z;
    logic [SQ_W-1:0]         rem;
    logic [SQ_W-1:0]         root;
  } c2p_cell_t;

  // atan(2^-stage) in Q60, taylor series in Q62 then rounded
  function automatic logic [CW-1:0] atan_q60(input int stage);
    logic [63:0] sum;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] den;
    logic [63:0] res;
    int          sh;
    int          k;
    int          b;
    sum = '0;
    if (stage == 0) begin
      res = (PI_Q60 + 64'd2) >> 2;
    end else begin
      for (k = 0; k < 32; k++) begin
        sh = stage * (2 * k + 1);
        if (sh <= 62) begin
          num = 64'd1 << (62 - sh);
          den = 64'(2 * k + 1);
          rem = '0;
          quo = '0;
          // restoring long division
          for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
              rem    = rem - den;
              quo[b] = 1'b1;
            end
          end
          if ((k % 2) == 1) begin
            sum = sum - quo;
          end else begin
            sum = sum + quo;
          end
        end
      end
      res = (sum + 64'd2) >> 2;
    end
    return res[CW-1:0];
  endfunction

  // round(pi * 2^frac)
  function automatic logic [ANG_W-1:0] pi_scaled(input int frac);
    logic [63:0] tmp;
    tmp = (PI_Q60 + (64'd1 << (59 - frac))) >> (60 - frac);
    return tmp[ANG_W-1:0];
  endfunction

endpackage

// ===== rtl/c2p_in_if.sv =====
interface c2p_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic signed [31:0] current_angle;

  modport source (output valid, x_pos, y_pos, current_angle, input ready);
  modport sink (input valid, x_pos, y_pos, current_angle, output ready);
endinterface

// ===== rtl/c2p_out_if.sv =====
interface c2p_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        radius;
  logic signed [31:0] new_angle;
  logic signed [31:0] folded_angle;
  logic               at_origin;

  modport source (output valid, radius, new_angle, folded_angle, at_origin, input ready);
  modport sink (input valid, radius, new_angle, folded_angle, at_origin, output ready);
endinterface

// ===== rtl/cartesian_to_polar_unwrap.sv =====
// Cartesian to polar conversion with angle unwrapping.
// pos_in carries an XY point (Q15.16) and the commanded angle; polar_out
// returns the floored radius, the atan2 angle unwrapped against the
// commanded angle (deadband and origin keep it), the commanded angle folded
// once toward [-pi, pi], and an origin flag. One result per item.
// cfg_wr_en / cfg_wr_data load the 16-bit angle deadband; write it idle.
// Throughput: one item per cycle while polar_out.ready is high.
// Pipeline from acceptance to valid output: 5 front stages (capture, abs,
// square and normalize, sum, scale), one cell per CORDIC rotation / square
// root bit, then 4 unwrap stages and the output register.
// Reset empties the pipeline, the skid slot and the output register and
// sets the deadband to 268.
// A stall on polar_out holds the whole pipeline; one item arriving in the
// stall cycle lands in a skid slot, pos_in.ready comes from that slot's flag.
`include "cartesian_to_polar_unwrap_defines.svh"

module cartesian_to_polar_unwrap #(
  parameter int CORDIC_STAGES   = 32,
  parameter int ANGLE_FRAC_BITS = 28
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  c2p_in_if.sink            pos_in,
  c2p_out_if.source         polar_out
);

  localparam int NCELL = (CORDIC_STAGES > int'(c2p_pkg::SQRT_STEPS)) ?
                         CORDIC_STAGES : int'(c2p_pkg::SQRT_STEPS);

  logic [c2p_pkg::DB_W-1:0] deadband;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= c2p_pkg::DEADBAND_RESET;
    end else if (cfg_wr_en) begin
      deadband <= cfg_wr_data;
    end
  end

  // pipeline advance and skid slot
  logic               en;
  logic               out_valid;
  logic               skid_full;
  logic signed [31:0] skid_x;
  logic signed [31:0] skid_y;
  logic signed [31:0] skid_cur;
  logic               src_valid;
  logic signed [31:0] src_x;
  logic signed [31:0] src_y;
  logic signed [31:0] src_cur;

  assign en           = !out_valid || polar_out.ready;
  assign pos_in.ready = !skid_full;
  assign src_valid    = skid_full || pos_in.valid;
  assign src_x        = skid_full ? skid_x : pos_in.x_pos;
  assign src_y        = skid_full ? skid_y : pos_in.y_pos;
  assign src_cur      = skid_full ? skid_cur : pos_in.current_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (en) begin
      skid_full <= 1'b0;
    end else if (pos_in.valid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && !skid_full) begin
      skid_x   <= pos_in.x_pos;
      skid_y   <= pos_in.y_pos;
      skid_cur <= pos_in.current_angle;
    end
  end

  c2p_pkg::c2p_cell_t chain [NCELL+1];

  c2p_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .src_valid (src_valid),
    .src_x     (src_x),
    .src_y     (src_y),
    .src_cur   (src_cur),
    .head      (chain[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    c2p_cell #(
      .STAGE        (g),
      .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (chain[g]),
      .q   (chain[g+1])
    );
  end

  c2p_unwrap #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_unwrap (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .tail         (chain[NCELL]),
    .deadband     (deadband),
    .out_valid    (out_valid),
    .radius       (polar_out.radius),
    .new_angle    (polar_out.new_angle),
    .folded_angle (polar_out.folded_angle),
    .at_origin    (polar_out.at_origin)
  );

  assign polar_out.valid = out_valid;

  `C2P_ASSERT_SAME(a_origin_zero_radius, rst, polar_out.valid && polar_out.at_origin, polar_out.radius == 32'd0, "origin item with nonzero radius")
  `C2P_ASSERT_NEXT(a_skid_drains, rst, skid_full && en, !skid_full, "skid slot not drained on advance")
  `C2P_ASSERT_NEXT(a_skid_no_fill, rst, !skid_full && en, !skid_full, "skid slot filled while advancing")
  `C2P_ASSERT_SAME(a_reset_empty, 1'b0, $past(rst), !out_valid && !skid_full, "pipeline not empty after reset")

endmodule

// ===== rtl/c2p_front.sv =====
module c2p_front #(
  parameter int ANGLE_FRAC_BITS = 28
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      src_valid,
  input  logic signed [31:0]        src_x,
  input  logic signed [31:0]        src_y,
  input  logic signed [31:0]        src_cur,
  output c2p_pkg::c2p_cell_t        head
);

  localparam int unsigned AW = c2p_pkg::ANG_W;
  localparam int unsigned CW = c2p_pkg::CW;
  localparam logic signed [AW-1:0] PI_A     = c2p_pkg::pi_scaled(ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] TWO_PI_A = PI_A <<< 1;
  localparam logic signed [CW-1:0] HALF_PI  = c2p_pkg::HALF_PI_Q60[CW-1:0];

  // stage 1: raw capture
  logic               v1;
  logic signed [31:0] x1;
  logic signed [31:0] y1;
  logic signed [31:0] c1;

  always_ff @(posedge clk) begin
    if (en) begin
      v1 <= src_valid;
      x1 <= src_x;
      y1 <= src_y;
      c1 <= src_cur;
    end
    if (rst) begin
      v1 <= 1'b0;
    end
  end

  // stage 2: magnitudes, signs, fold candidates
  logic                v2;
  logic [31:0]         ax2;
  logic [31:0]         ay2;
  logic                sx2;
  logic                sy2;
  logic                org2;
  logic signed [31:0]  c2;
  logic                lo2;
  logic                hi2;
  logic signed [31:0]  cp2;
  logic signed [31:0]  cm2;
  logic signed [AW-1:0] c1w;
  logic signed [AW-1:0] cp1;
  logic signed [AW-1:0] cm1;

  assign c1w = AW'(c1);
  assign cp1 = c1w + TWO_PI_A;
  assign cm1 = c1w - TWO_PI_A;

  always_ff @(posedge clk) begin
    if (en) begin
      v2   <= v1;
      ax2  <= x1[31] ? (~x1 + 32'd1) : x1;
      ay2  <= y1[31] ? (~y1 + 32'd1) : y1;
      sx2  <= x1[31];
      sy2  <= y1[31];
      org2 <= (x1 == 32'sd0) && (y1 == 32'sd0);
      c2   <= c1;
      lo2  <= c1w < -PI_A;
      hi2  <= c1w > PI_A;
      cp2  <= cp1[31:0];
      cm2  <= cm1[31:0];
    end
    if (rst) begin
      v2 <= 1'b0;
    end
  end

  // stage 3: squares, coarse normalize
  logic               v3;
  logic [63:0]        sqx3;
  logic [63:0]        sqy3;
  logic [31:0]        nx3;
  logic [31:0]        ny3;
  logic [31:0]        no3;
  logic               sx3;
  logic               sy3;
  logic               org3;
  logic signed [31:0] c3;
  logic signed [31:0] f3;
  logic [31:0]        na_x;
  logic [31:0]        na_y;
  logic [31:0]        na_o;
  logic [63:0]        px;
  logic [63:0]        py;

  assign px = 64'(ax2) * 64'(ax2);
  assign py = 64'(ay2) * 64'(ay2);

  always_comb begin
    na_x = ax2;
    na_y = ay2;
    na_o = ax2 | ay2;
    if (na_o[31:16] == 16'd0) begin
      na_x = na_x << 16;
      na_y = na_y << 16;
      na_o = na_o << 16;
    end
    if (na_o[31:24] == 8'd0) begin
      na_x = na_x << 8;
      na_y = na_y << 8;
      na_o = na_o << 8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v3   <= v2;
      sqx3 <= px;
      sqy3 <= py;
      nx3  <= na_x;
      ny3  <= na_y;
      no3  <= na_o;
      sx3  <= sx2;
      sy3  <= sy2;
      org3 <= org2;
      c3   <= c2;
      f3   <= lo2 ? cp2 : (hi2 ? cm2 : c2);
    end
    if (rst) begin
      v3 <= 1'b0;
    end
  end

  // stage 4: sum of squares, fine normalize
  logic               v4;
  logic [63:0]        sum4;
  logic [31:0]        nx4;
  logic [31:0]        ny4;
  logic               sx4;
  logic               sy4;
  logic               org4;
  logic signed [31:0] c4;
  logic signed [31:0] f4;
  logic [31:0]        nb_x;
  logic [31:0]        nb_y;
  logic [31:0]        nb_o;

  always_comb begin
    nb_x = nx3;
    nb_y = ny3;
    nb_o = no3;
    if (nb_o[31:28] == 4'd0) begin
      nb_x = nb_x << 4;
      nb_y = nb_y << 4;
      nb_o = nb_o << 4;
    end
    if (nb_o[31:30] == 2'd0) begin
      nb_x = nb_x << 2;
      nb_y = nb_y << 2;
      nb_o = nb_o << 2;
    end
    if (!nb_o[31]) begin
      nb_x = nb_x << 1;
      nb_y = nb_y << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v4   <= v3;
      sum4 <= sqx3 + sqy3;
      nx4  <= nb_x;
      ny4  <= nb_y;
      sx4  <= sx3;
      sy4  <= sy3;
      org4 <= org3;
      c4   <= c3;
      f4   <= f3;
    end
    if (rst) begin
      v4 <= 1'b0;
    end
  end

  // stage 5: scale into [2^59, 2^60) and pre-rotate left half plane by pi/2
  c2p_pkg::c2p_cell_t  head_next;
  logic signed [CW-1:0] big_x;
  logic signed [CW-1:0] big_y;
  logic signed [CW-1:0] y_mag;

  assign big_x = {3'b000, nx4, 28'd0};
  assign big_y = {3'b000, ny4, 28'd0};
  assign y_mag = sx4 ? big_x : big_y;

  always_comb begin
    head_next        = head;
    head_next.valid  = v4;
    head_next.origin = org4;
    head_next.cur    = c4;
    head_next.folded = f4;
    head_next.x      = sx4 ? big_y : big_x;
    head_next.y      = sy4 ? -y_mag : y_mag;
    head_next.z      = sx4 ? (sy4 ? -HALF_PI : HALF_PI) : '0;
    head_next.rem    = sum4;
    head_next.root   = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head <= head_next;
    end
    if (rst) begin
      head.valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/c2p_cell.sv =====
module c2p_cell #(
  parameter int STAGE         = 0,
  parameter int CORDIC_STAGES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  c2p_pkg::c2p_cell_t d,
  output c2p_pkg::c2p_cell_t q
);

  localparam int unsigned CW   = c2p_pkg::CW;
  localparam int unsigned SW   = c2p_pkg::SQ_W;
  localparam bit DO_ROT  = (STAGE < CORDIC_STAGES);
  localparam bit DO_ROOT = (STAGE < c2p_pkg::SQRT_STEPS);
  localparam int ROOT_SH = DO_ROOT ? (62 - 2 * STAGE) : 0;
  localparam logic signed [CW-1:0] ATAN = DO_ROT ? c2p_pkg::atan_q60(STAGE) : '0;
  localparam logic [SW-1:0] ROOT_BIT = DO_ROOT ? (64'd1 << ROOT_SH) : '0;

  c2p_pkg::c2p_cell_t   q_next;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic [SW-1:0]        trial;

  assign dx    = d.y >>> STAGE;
  assign dy    = d.x >>> STAGE;
  assign trial = d.root + ROOT_BIT;

  always_comb begin
    q_next = d;
    if (DO_ROT) begin
      // rotate toward the x axis
      if (!d.y[CW-1]) begin
        q_next.x = d.x + dx;
        q_next.y = d.y - dy;
        q_next.z = d.z + ATAN;
      end else begin
        q_next.x = d.x - dx;
        q_next.y = d.y + dy;
        q_next.z = d.z - ATAN;
      end
    end
    if (DO_ROOT) begin
      // one result bit of the integer square root
      if (d.rem >= trial) begin
        q_next.rem  = d.rem - trial;
        q_next.root = (d.root >> 1) + ROOT_BIT;
      end else begin
        q_next.root = d.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
    if (rst) begin
      q.valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/c2p_unwrap.sv =====
module c2p_unwrap #(
  parameter int ANGLE_FRAC_BITS = 28
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  c2p_pkg::c2p_cell_t  tail,
  input  logic [15:0]         deadband,
  output logic                out_valid,
  output logic [31:0]         radius,
  output logic signed [31:0]  new_angle,
  output logic signed [31:0]  folded_angle,
  output logic                at_origin
);

  localparam int unsigned AW = c2p_pkg::ANG_W;
  localparam int unsigned CW = c2p_pkg::CW;
  localparam int          SH = 60 - ANGLE_FRAC_BITS;
  localparam logic signed [CW-1:0] RND      = CW'(1) <<< (59 - ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] PI_A     = c2p_pkg::pi_scaled(ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] TWO_PI_A = PI_A <<< 1;
  localparam logic signed [AW-1:0] MAX32    = {{(AW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [AW-1:0] MIN32    = ~MAX32;

  // stage 1: round the angle
  logic signed [CW-1:0] z_rnd;
  logic                 v1;
  logic signed [AW-1:0] ang1;
  logic signed [31:0]   c1;
  logic signed [31:0]   f1;
  logic [31:0]          r1;
  logic                 o1;

  assign z_rnd = tail.z + RND;

  always_ff @(posedge clk) begin
    if (en) begin
      v1   <= tail.valid;
      ang1 <= AW'(z_rnd >>> SH);
      c1   <= tail.cur;
      f1   <= tail.folded;
      r1   <= tail.root[31:0];
      o1   <= tail.origin;
    end
    if (rst) begin
      v1 <= 1'b0;
    end
  end

  // stage 2: difference to the current angle
  logic                 v2;
  logic signed [AW-1:0] diff2;
  logic signed [31:0]   c2;
  logic signed [31:0]   f2;
  logic [31:0]          r2;
  logic                 o2;

  always_ff @(posedge clk) begin
    if (en) begin
      v2    <= v1;
      diff2 <= ang1 - AW'(c1);
      c2    <= c1;
      f2    <= f1;
      r2    <= r1;
      o2    <= o1;
    end
    if (rst) begin
      v2 <= 1'b0;
    end
  end

  // stage 3: single wrap by 2pi
  logic                 v3;
  logic signed [AW-1:0] dw3;
  logic signed [31:0]   c3;
  logic signed [31:0]   f3;
  logic [31:0]          r3;
  logic                 o3;
  logic signed [AW-1:0] dw_next;

  always_comb begin
    if (diff2 > PI_A) begin
      dw_next = diff2 - TWO_PI_A;
    end else if (diff2 < -PI_A) begin
      dw_next = diff2 + TWO_PI_A;
    end else begin
      dw_next = diff2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v3  <= v2;
      dw3 <= dw_next;
      c3  <= c2;
      f3  <= f2;
      r3  <= r2;
      o3  <= o2;
    end
    if (rst) begin
      v3 <= 1'b0;
    end
  end

  // stage 4: deadband test and unwrapped sum
  logic                 v4;
  logic                 keep4;
  logic signed [AW-1:0] sum4;
  logic signed [31:0]   c4;
  logic signed [31:0]   f4;
  logic [31:0]          r4;
  logic                 o4;
  logic signed [AW-1:0] dbw;

  assign dbw = $signed({{(AW - 16){1'b0}}, deadband});

  always_ff @(posedge clk) begin
    if (en) begin
      v4    <= v3;
      keep4 <= o3 || ((dw3 < dbw) && (dw3 > -dbw));
      sum4  <= AW'(c3) + dw3;
      c4    <= c3;
      f4    <= f3;
      r4    <= r3;
      o4    <= o3;
    end
    if (rst) begin
      v4 <= 1'b0;
    end
  end

  // output register
  logic signed [31:0] sat4;

  always_comb begin
    if (sum4 > MAX32) begin
      sat4 = MAX32[31:0];
    end else if (sum4 < MIN32) begin
      sat4 = MIN32[31:0];
    end else begin
      sat4 = sum4[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_valid    <= v4;
      radius       <= r4;
      new_angle    <= keep4 ? c4 : sat4;
      folded_angle <= f4;
      at_origin    <= o4;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end
  end

endmodule
